### hw/rtl/inverter_fault_debounce_latch_top_defines.svh
// Assertion macros for the inverter fault debounce and latch block.
`ifndef INVERTER_FAULT_DEBOUNCE_LATCH_TOP_DEFINES_SVH
`define INVERTER_FAULT_DEBOUNCE_LATCH_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IFDL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IFDL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ifdl_pkg.sv
// Package: widths, op codes, register indexes, sensing modes, fault bit positions and reset values.
package ifdl_pkg;

    localparam int unsigned DataW    = 24;
    localparam int unsigned LimW     = 23;
    localparam int unsigned CntW     = 8;
    localparam int unsigned ModeW    = 3;
    localparam int unsigned OpW      = 2;
    localparam int unsigned NumClass = 4;
    localparam int unsigned LatchW   = 5;
    localparam int unsigned CfgIdxW  = 3;

    localparam logic [CntW-1:0] CntMax = '1;

    // op codes
    localparam logic [OpW-1:0] OP_SCAN  = 2'd0;
    localparam logic [OpW-1:0] OP_LATCH = 2'd1;
    localparam logic [OpW-1:0] OP_CLEAR = 2'd2;

    // register indexes
    localparam logic [CfgIdxW-1:0] REG_UV_LIMIT  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_OV_LIMIT  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_OC_LIMIT  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_IMB_LIMIT = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TRIP_CNT  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_SENSE_MD  = 3'd5;

    // sensing modes
    localparam logic [ModeW-1:0] MODE_ALL     = 3'd0;
    localparam logic [ModeW-1:0] MODE_DC_BOTH = 3'd1;
    localparam logic [ModeW-1:0] MODE_CUR     = 3'd2;
    localparam logic [ModeW-1:0] MODE_DC1     = 3'd3;
    localparam logic [ModeW-1:0] MODE_DC2     = 3'd4;

    // fault bit positions
    localparam int unsigned FLT_UV   = 0;
    localparam int unsigned FLT_OV   = 1;
    localparam int unsigned FLT_OC   = 2;
    localparam int unsigned FLT_IMB  = 3;

    // register reset values
    localparam logic signed [DataW-1:0] RstUvLimit  = 24'sd0;
    localparam logic signed [DataW-1:0] RstOvLimit  = 24'sd8388607;
    localparam logic [LimW-1:0]         RstOcLimit  = '1;
    localparam logic [LimW-1:0]         RstImbLimit = '1;
    localparam logic [CntW-1:0]         RstTripCnt  = 8'd3;
    localparam logic [ModeW-1:0]        RstSenseMd  = 3'd0;

    typedef logic [NumClass-1:0] t_flags;

endpackage

### hw/rtl/inverter_fault_debounce_latch_top.sv
// Top level: inverter fault check, debounce counters and fault latch.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | into      | i_in_valid / o_in_ready    | op, sensor flags, voltages, current
//  out     | out of    | o_out_valid / i_out_ready  | tripped, sensor lost, latch
//  cfg     | into      | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while i_out_ready stays high.
// Limit compares and abs values are formed on the way into the input register;
// the counter update and latch sit between the input and result registers.
// A stalled result holds the input register; the input side stays ready while
// that register is empty or moving. Reset (synchronous, active low) clears
// counters, latch, valids and sets registers to their defaults.
`include "inverter_fault_debounce_latch_top_defines.svh"

module inverter_fault_debounce_latch_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [ifdl_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [ifdl_pkg::DataW-1:0]          i_cfg_data,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ifdl_pkg::OpW-1:0]            i_op,
    input  logic                                i_sensor_present,
    input  logic signed [ifdl_pkg::DataW-1:0]   i_dc1_voltage,
    input  logic signed [ifdl_pkg::DataW-1:0]   i_dc2_voltage,
    input  logic signed [ifdl_pkg::DataW-1:0]   i_phase_current,
    input  logic                                i_current_available,
    input  logic [ifdl_pkg::LatchW-1:0]         i_latch_bits,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ifdl_pkg::NumClass-1:0]       o_tripped_faults,
    output logic                                o_sensor_lost,
    output logic [ifdl_pkg::LatchW-1:0]         o_latched_faults
);
    import ifdl_pkg::*;

    // configuration registers
    logic signed [DataW-1:0] r_uv_limit;
    logic signed [DataW-1:0] r_ov_limit;
    logic [LimW-1:0]         r_oc_limit;
    logic [LimW-1:0]         r_imb_limit;
    logic [CntW-1:0]         r_trip_cnt;
    logic [ModeW-1:0]        r_sense_md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv_limit  <= RstUvLimit;
            r_ov_limit  <= RstOvLimit;
            r_oc_limit  <= RstOcLimit;
            r_imb_limit <= RstImbLimit;
            r_trip_cnt  <= RstTripCnt;
            r_sense_md  <= RstSenseMd;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_UV_LIMIT:  r_uv_limit  <= i_cfg_data;
                REG_OV_LIMIT:  r_ov_limit  <= i_cfg_data;
                REG_OC_LIMIT:  r_oc_limit  <= i_cfg_data[LimW-1:0];
                REG_IMB_LIMIT: r_imb_limit <= i_cfg_data[LimW-1:0];
                REG_TRIP_CNT:  r_trip_cnt  <= i_cfg_data[CntW-1:0];
                REG_SENSE_MD:  r_sense_md  <= i_cfg_data[ModeW-1:0];
                default: ;
            endcase
        end
    end

    // instant fault flags from the incoming item
    logic signed [DataW:0] s_cur_ext;
    logic signed [DataW:0] s_diff;
    logic [DataW:0]        s_cur_abs;
    logic [DataW:0]        s_diff_abs;
    logic [1:0]            s_dc1_flt;
    logic [1:0]            s_dc2_flt;
    logic                  s_oc_flt;
    logic                  s_imb_flt;
    t_flags                s_inst;

    always_comb begin
        s_cur_ext  = {i_phase_current[DataW-1], i_phase_current};
        s_diff     = {i_dc1_voltage[DataW-1], i_dc1_voltage}
                   - {i_dc2_voltage[DataW-1], i_dc2_voltage};
        s_cur_abs  = s_cur_ext[DataW] ? (DataW+1)'(-s_cur_ext) : (DataW+1)'(s_cur_ext);
        s_diff_abs = s_diff[DataW] ? (DataW+1)'(-s_diff) : (DataW+1)'(s_diff);

        s_dc1_flt  = {i_dc1_voltage > r_ov_limit, i_dc1_voltage < r_uv_limit};
        s_dc2_flt  = {i_dc2_voltage > r_ov_limit, i_dc2_voltage < r_uv_limit};
        s_oc_flt   = s_cur_abs > {2'b00, r_oc_limit};
        s_imb_flt  = s_diff_abs > {2'b00, r_imb_limit};

        s_inst = '0;
        unique case (r_sense_md)
            MODE_ALL: begin
                s_inst[FLT_OV:FLT_UV] = s_dc1_flt | s_dc2_flt;
                s_inst[FLT_OC]        = s_oc_flt;
                s_inst[FLT_IMB]       = s_imb_flt;
            end
            MODE_DC_BOTH: begin
                s_inst[FLT_OV:FLT_UV] = s_dc1_flt | s_dc2_flt;
                s_inst[FLT_IMB]       = s_imb_flt;
            end
            MODE_CUR: begin
                s_inst[FLT_OC] = s_oc_flt;
            end
            MODE_DC1: begin
                s_inst[FLT_OV:FLT_UV] = s_dc1_flt;
                s_inst[FLT_OC]        = i_current_available & s_oc_flt;
            end
            MODE_DC2: begin
                s_inst[FLT_OV:FLT_UV] = s_dc2_flt;
                s_inst[FLT_OC]        = i_current_available & s_oc_flt;
            end
            default: s_inst = '0; // open loop
        endcase
    end

    // input register
    logic               r_s1_valid;
    logic [OpW-1:0]     r_s1_op;
    logic               r_s1_present;
    t_flags             r_s1_inst;
    logic [LatchW-1:0]  r_s1_latch;
    logic               w_adv;

    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_op      <= i_op;
            r_s1_present <= i_sensor_present;
            r_s1_inst    <= s_inst;
            r_s1_latch   <= i_latch_bits;
        end
    end

    // debounce counters and latch
    logic [CntW-1:0]   r_cnt [NumClass];
    logic [CntW-1:0]   n_cnt [NumClass];
    logic [CntW-1:0]   s_inc [NumClass];
    logic [LatchW-1:0] r_latched;
    logic [LatchW-1:0] n_latched;
    t_flags            n_tripped;
    logic              n_lost;

    always_comb begin
        n_latched = r_latched;
        n_tripped = '0;
        n_lost    = 1'b0;
        for (int k = 0; k < NumClass; k++) begin
            n_cnt[k] = r_cnt[k];
            s_inc[k] = (r_cnt[k] == CntMax) ? r_cnt[k] : r_cnt[k] + 1'b1;
        end
        unique case (r_s1_op)
            OP_SCAN: begin
                if (!r_s1_present) begin
                    n_lost = 1'b1;
                end else begin
                    for (int k = 0; k < NumClass; k++) begin
                        n_cnt[k]     = r_s1_inst[k] ? s_inc[k] : '0;
                        n_tripped[k] = r_s1_inst[k] && (s_inc[k] >= r_trip_cnt);
                    end
                end
            end
            OP_LATCH: n_latched = r_latched | r_s1_latch;
            OP_CLEAR: begin
                n_latched = '0;
                for (int k = 0; k < NumClass; k++) begin
                    n_cnt[k] = '0;
                end
            end
            default: ; // unused op: no change
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched <= '0;
            for (int k = 0; k < NumClass; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (w_adv && r_s1_valid) begin
            r_latched <= n_latched;
            for (int k = 0; k < NumClass; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            o_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            o_tripped_faults <= n_tripped;
            o_sensor_lost    <= n_lost;
            o_latched_faults <= n_latched;
        end
    end

    `IFDL_ASSERT_NOW(a_lost_no_trip, o_out_valid && o_sensor_lost,
        o_tripped_faults == '0, "tripped faults reported on a scan without sensor frame")

    `IFDL_ASSERT_NOW(a_trip_needs_count, o_out_valid && (o_tripped_faults != '0),
        (!o_tripped_faults[FLT_UV] || r_cnt[FLT_UV] != '0) &&
        (!o_tripped_faults[FLT_OV] || r_cnt[FLT_OV] != '0) &&
        (!o_tripped_faults[FLT_OC] || r_cnt[FLT_OC] != '0) &&
        (!o_tripped_faults[FLT_IMB] || r_cnt[FLT_IMB] != '0),
        "fault tripped with a zero debounce count")

    `IFDL_ASSERT_NEXT(a_clear_empties, w_adv && r_s1_valid && r_s1_op == OP_CLEAR,
        r_latched == '0 && r_cnt[FLT_UV] == '0 && r_cnt[FLT_OV] == '0 &&
        r_cnt[FLT_OC] == '0 && r_cnt[FLT_IMB] == '0 && o_latched_faults == '0,
        "clear item left latch or counters nonzero")

    `IFDL_ASSERT_NEXT(a_latch_sticky, !(w_adv && r_s1_valid && r_s1_op == OP_CLEAR),
        (r_latched & $past(r_latched)) == $past(r_latched),
        "latched fault bit dropped without a clear item")

endmodule

### bench/tb.sv
// Testbench for the inverter fault debounce and latch block: random items checked against a predictor.
module tb;
    import ifdl_pkg::*;

    localparam logic [OpW-1:0]   OP_NONE       = 2'd3;
    localparam logic [ModeW-1:0] MODE_OPEN_LO  = 3'd5;
    localparam logic [ModeW-1:0] MODE_OPEN_MID = 3'd6;
    localparam logic [ModeW-1:0] MODE_OPEN_HI  = 3'd7;
    localparam int DcMin      = -8388608;
    localparam int DcMax      = 8388607;
    localparam int CurMagMax  = 8388608;
    localparam int CycleLimit = 300000;

    typedef struct packed {
        logic [OpW-1:0]          op;
        logic                    sensor_present;
        logic signed [DataW-1:0] dc1;
        logic signed [DataW-1:0] dc2;
        logic signed [DataW-1:0] current;
        logic                    current_available;
        logic [LatchW-1:0]       latch_bits;
    } t_scan_item;

    typedef struct packed {
        t_flags            tripped;
        logic              lost;
        logic [LatchW-1:0] latched;
    } t_fault_report;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]      i_cfg_idx = '0;
    logic [DataW-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [OpW-1:0]          i_op = '0;
    logic                    i_sensor_present = 1'b0;
    logic signed [DataW-1:0] i_dc1_voltage = '0;
    logic signed [DataW-1:0] i_dc2_voltage = '0;
    logic signed [DataW-1:0] i_phase_current = '0;
    logic                    i_current_available = 1'b0;
    logic [LatchW-1:0]       i_latch_bits = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [NumClass-1:0]     o_tripped_faults;
    logic                    o_sensor_lost;
    logic [LatchW-1:0]       o_latched_faults;

    inverter_fault_debounce_latch_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_sensor_present   (i_sensor_present),
        .i_dc1_voltage      (i_dc1_voltage),
        .i_dc2_voltage      (i_dc2_voltage),
        .i_phase_current    (i_phase_current),
        .i_current_available(i_current_available),
        .i_latch_bits       (i_latch_bits),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_tripped_faults   (o_tripped_faults),
        .o_sensor_lost      (o_sensor_lost),
        .o_latched_faults   (o_latched_faults)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of settings and state
    int             cfg_uv = RstUvLimit;
    int             cfg_ov = RstOvLimit;
    int             cfg_oc = RstOcLimit;
    int             cfg_imb = RstImbLimit;
    logic [CntW-1:0]  cfg_trip = RstTripCnt;
    logic [ModeW-1:0] cfg_mode = RstSenseMd;
    logic [CntW-1:0]  fault_cnt [NumClass];
    logic [LatchW-1:0] latch_state = '0;

    t_scan_item    pending_items[$];
    t_fault_report expected_reports[$];

    bit   item_taken;
    int   burst_left;
    int   gap_left;
    int   ready_left;
    logic [31:0] ready_pattern;
    int   cycle_count;
    int   fail_count;
    int   results_checked;
    int   trips_seen;
    int   lost_seen;
    int   settings_run;

    initial begin
        for (int k = 0; k < NumClass; k++) fault_cnt[k] = '0;
    end

    function automatic t_flags dc_flags(input int v);
        t_flags f;
        f = '0;
        f[FLT_UV] = (v < cfg_uv);
        f[FLT_OV] = (v > cfg_ov);
        return f;
    endfunction

    function automatic t_fault_report predict_report(input t_scan_item it);
        t_fault_report rep;
        t_flags        hit;
        int            d1, d2, cur_mag, spread;
        logic          oc_hit, imb_hit;
        rep = '0;
        hit = '0;
        d1 = signed'(it.dc1);
        d2 = signed'(it.dc2);
        cur_mag = signed'(it.current);
        if (cur_mag < 0) cur_mag = -cur_mag;
        spread = d1 - d2;
        if (spread < 0) spread = -spread;
        oc_hit = (cur_mag > cfg_oc);
        imb_hit = (spread > cfg_imb);
        case (it.op)
            OP_SCAN: begin
                if (!it.sensor_present) begin
                    rep.lost = 1'b1;
                end else begin
                    case (cfg_mode)
                        MODE_ALL: begin
                            hit = dc_flags(d1) | dc_flags(d2);
                            hit[FLT_OC] = oc_hit;
                            hit[FLT_IMB] = imb_hit;
                        end
                        MODE_DC_BOTH: begin
                            hit = dc_flags(d1) | dc_flags(d2);
                            hit[FLT_IMB] = imb_hit;
                        end
                        MODE_CUR: hit[FLT_OC] = oc_hit;
                        MODE_DC1: begin
                            hit = dc_flags(d1);
                            hit[FLT_OC] = oc_hit && it.current_available;
                        end
                        MODE_DC2: begin
                            hit = dc_flags(d2);
                            hit[FLT_OC] = oc_hit && it.current_available;
                        end
                        default: ;
                    endcase
                    for (int k = 0; k < NumClass; k++) begin
                        if (hit[k]) begin
                            if (fault_cnt[k] != CntMax) fault_cnt[k] = fault_cnt[k] + 1'b1;
                            rep.tripped[k] = (fault_cnt[k] >= cfg_trip);
                        end else begin
                            fault_cnt[k] = '0;
                        end
                    end
                end
            end
            OP_LATCH: latch_state = latch_state | it.latch_bits;
            OP_CLEAR: begin
                latch_state = '0;
                for (int k = 0; k < NumClass; k++) fault_cnt[k] = '0;
            end
            default: ;
        endcase
        rep.latched = latch_state;
        return rep;
    endfunction

    function automatic void check_field(input string field, input logic [LatchW-1:0] want,
                                        input logic [LatchW-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    // result check first, then prediction of the item taken at this edge
    always @(posedge i_clk) begin : scoreboard
        t_scan_item    taken;
        t_fault_report want;
        cycle_count++;
        item_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result item with no item outstanding");
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("tripped_faults", LatchW'(want.tripped), LatchW'(o_tripped_faults));
                    check_field("sensor_lost", LatchW'(want.lost), LatchW'(o_sensor_lost));
                    check_field("latched_faults", want.latched, o_latched_faults);
                    results_checked++;
                    if (want.tripped != '0) trips_seen++;
                    if (want.lost) lost_seen++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                item_taken = 1'b1;
                taken.op = i_op;
                taken.sensor_present = i_sensor_present;
                taken.dc1 = i_dc1_voltage;
                taken.dc2 = i_dc2_voltage;
                taken.current = i_phase_current;
                taken.current_available = i_current_available;
                taken.latch_bits = i_latch_bits;
                expected_reports.push_back(predict_report(taken));
            end
        end
    end

    // sender: bursts of items separated by random gaps
    always @(negedge i_clk) begin : item_feeder
        t_scan_item nxt;
        logic       drive_valid;
        drive_valid = i_in_valid && !item_taken;
        if (i_rst_n && !drive_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() > 0) begin
                nxt = pending_items.pop_front();
                i_op <= nxt.op;
                i_sensor_present <= nxt.sensor_present;
                i_dc1_voltage <= nxt.dc1;
                i_dc2_voltage <= nxt.dc2;
                i_phase_current <= nxt.current;
                i_current_available <= nxt.current_available;
                i_latch_bits <= nxt.latch_bits;
                drive_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(9) < 4) ? 0 : $urandom_range(1, 8);
                    if ($urandom_range(19) == 0) gap_left = 25;
                end
            end
        end
        i_in_valid <= drive_valid;
    end

    // receiver: random stall pattern, reloaded once it is used up
    always @(negedge i_clk) begin : result_sink
        if (ready_left == 0) begin
            case ($urandom_range(3))
                0: ready_pattern = '1;
                1: ready_pattern = $urandom & $urandom;
                default: ready_pattern = $urandom;
            endcase
            ready_left = 32;
        end
        i_out_ready <= ready_pattern[0];
        ready_pattern = ready_pattern >> 1;
        ready_left--;
    end

    initial begin : watchdog
        wait (cycle_count >= CycleLimit);
        $display("timeout after %0d cycles", cycle_count);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int rand_edge(input int lo, input int hi);
        case ($urandom_range(3))
            0: return lo;
            1: return hi;
            default: return lo + int'($urandom_range(hi - lo));
        endcase
    endfunction

    function automatic int pick_dc(input logic want_uv, input logic want_ov);
        if (want_uv && cfg_uv > DcMin) return rand_edge(DcMin, cfg_uv - 1);
        if (want_ov && cfg_ov < DcMax) return rand_edge(cfg_ov + 1, DcMax);
        if (cfg_uv <= cfg_ov) return rand_edge(cfg_uv, cfg_ov);
        return rand_edge(DcMin, DcMax);
    endfunction

    function automatic int pick_current(input logic want_oc);
        int mag;
        if (want_oc) mag = rand_edge(cfg_oc + 1, CurMagMax);
        else mag = rand_edge(0, cfg_oc);
        if (mag == CurMagMax || $urandom_range(1) == 1) return -mag;
        return mag;
    endfunction

    function automatic t_scan_item random_item(input logic [OpW-1:0] op);
        t_scan_item it;
        it.op = op;
        it.sensor_present = 1'($urandom);
        it.dc1 = DataW'($urandom);
        it.dc2 = DataW'($urandom);
        it.current = DataW'($urandom);
        it.current_available = 1'($urandom);
        it.latch_bits = LatchW'($urandom);
        return it;
    endfunction

    // well-formed scan aimed at a set of instant faults
    function automatic t_scan_item make_scan(input t_flags goal);
        t_scan_item it;
        int         d1, d2, spread, sel;
        it = random_item(OP_SCAN);
        it.sensor_present = 1'b1;
        it.current_available = ($urandom_range(7) != 0);
        sel = $urandom_range(3);
        if (goal[FLT_UV] && goal[FLT_OV] && sel < 2) begin
            d1 = pick_dc(1'b1, 1'b0);
            d2 = pick_dc(1'b0, 1'b1);
        end else begin
            d1 = pick_dc(goal[FLT_UV] && sel != 3, goal[FLT_OV] && sel != 3);
            d2 = pick_dc(goal[FLT_UV] && sel != 2, goal[FLT_OV] && sel != 2);
        end
        spread = d1 - d2;
        if (spread < 0) spread = -spread;
        if (goal[FLT_IMB] && spread <= cfg_imb) begin
            spread = cfg_imb + 1 + int'($urandom_range(255));
            d2 = (d1 - spread >= DcMin) ? d1 - spread : d1 + spread;
            if (d2 > DcMax) d2 = DcMax;
        end else if (!goal[FLT_IMB] && spread > cfg_imb) begin
            spread = int'($urandom_range(cfg_imb));
            d2 = (d1 - spread >= DcMin) ? d1 - spread : d1 + spread;
        end
        it.dc1 = DataW'(d1);
        it.dc2 = DataW'(d2);
        it.current = DataW'(pick_current(goal[FLT_OC]));
        return it;
    endfunction

    task automatic add_item(input logic [OpW-1:0] op, input logic present, input int d1,
                            input int d2, input int cur, input logic cav,
                            input logic [LatchW-1:0] bits);
        t_scan_item it;
        it.op = op;
        it.sensor_present = present;
        it.dc1 = DataW'(d1);
        it.dc2 = DataW'(d2);
        it.current = DataW'(cur);
        it.current_available = cav;
        it.latch_bits = bits;
        pending_items.push_back(it);
    endtask

    // runs of scans with one fault target, so counters climb to the trip point
    task automatic queue_runs(input int n);
        int         made, run_len, r;
        t_flags     goal;
        bit         long_run;
        t_scan_item it;
        made = 0;
        while (made < n) begin
            long_run = (cfg_trip > 8'd32) && ($urandom_range(1) == 1);
            goal = ($urandom_range(9) < 3 && !long_run) ? t_flags'(0)
                                                         : t_flags'($urandom_range(1, 15));
            run_len = long_run ? $urandom_range(int'(cfg_trip) - 2, int'(cfg_trip) + 8)
                               : $urandom_range(1, int'(cfg_trip) + 4);
            for (int j = 0; j < run_len && made < n; j++) begin
                r = $urandom_range(99);
                if (r < 5) begin
                    it = random_item(OP_SCAN);
                    it.sensor_present = 1'b0;
                end else if (r < 9) begin
                    it = random_item(OP_LATCH);
                end else if (!long_run && r < 11) begin
                    it = random_item(OP_CLEAR);
                end else if (!long_run && r < 12) begin
                    it = random_item(OP_NONE);
                end else if (!long_run && r < 16) begin
                    it = random_item(OP_SCAN);
                end else begin
                    it = make_scan(goal);
                end
                pending_items.push_back(it);
                made++;
            end
        end
    endtask

    task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_UV_LIMIT:  cfg_uv = signed'(data);
            REG_OV_LIMIT:  cfg_ov = signed'(data);
            REG_OC_LIMIT:  cfg_oc = int'(data[LimW-1:0]);
            REG_IMB_LIMIT: cfg_imb = int'(data[LimW-1:0]);
            REG_TRIP_CNT:  cfg_trip = data[CntW-1:0];
            REG_SENSE_MD:  cfg_mode = data[ModeW-1:0];
            default: ;
        endcase
    endtask

    // unused upper data bits are filled with noise
    task automatic load_settings(input int uv, input int ov, input int oc, input int imb,
                                 input int trip, input logic [ModeW-1:0] mode);
        cfg_write(REG_UV_LIMIT, DataW'(uv));
        cfg_write(REG_OV_LIMIT, DataW'(ov));
        cfg_write(REG_OC_LIMIT, {1'($urandom), LimW'(oc)});
        cfg_write(REG_IMB_LIMIT, {1'($urandom), LimW'(imb)});
        cfg_write(REG_TRIP_CNT, {16'($urandom), CntW'(trip)});
        cfg_write(REG_SENSE_MD, {21'($urandom), mode});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || i_in_valid || expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int               uv;
        logic [ModeW-1:0] rand_mode;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: trip after 3, full sensing, lower voltage limit 0, other limits at their maximum
        add_item(OP_SCAN, 1'b1, 0, 0, 0, 1'b1, 5'd0);
        repeat (3) add_item(OP_SCAN, 1'b1, -1, 0, 0, 1'b1, 5'd0);
        add_item(OP_SCAN, 1'b1, DcMin, DcMax, DcMin, 1'b1, 5'd0);
        add_item(OP_SCAN, 1'b0, DcMin, DcMax, DcMin, 1'b1, 5'd31);
        repeat (2) add_item(OP_SCAN, 1'b1, DcMin, DcMax, DcMin, 1'b0, 5'd31);
        add_item(OP_LATCH, 1'b1, DcMin, DcMax, DcMin, 1'b1, 5'd1);
        add_item(OP_LATCH, 1'b0, 0, 0, 0, 1'b0, 5'd16);
        add_item(OP_NONE, 1'b1, DcMin, DcMin, DcMax, 1'b1, 5'd31);
        add_item(OP_CLEAR, 1'b1, -1, -1, -1, 1'b1, 5'd31);
        add_item(OP_SCAN, 1'b1, DcMin, DcMax, DcMin, 1'b1, 5'd0);
        add_item(OP_SCAN, 1'b1, DcMax, DcMin, DcMax, 1'b1, 5'd0);
        add_item(OP_SCAN, 1'b0, 0, 0, 0, 1'b0, 5'd0);
        add_item(OP_SCAN, 1'b1, DcMax, DcMax, 0, 1'b1, 5'd0);
        add_item(OP_LATCH, 1'b1, 0, 0, 0, 1'b1, 5'd31);
        add_item(OP_NONE, 1'b0, 0, 0, 0, 1'b0, 5'd0);
        add_item(OP_LATCH, 1'b0, 0, 0, 0, 1'b0, 5'd0);
        add_item(OP_CLEAR, 1'b0, 0, 0, 0, 1'b0, 5'd0);
        wait_idle();

        load_settings(51200, 102400, 25600, 12800, 3, MODE_ALL);
        queue_runs(60);
        wait_idle();
        queue_runs(60);
        wait_idle();
        load_settings(51200, 102400, 25600, 12800, 1, MODE_DC_BOTH);
        queue_runs(120);
        wait_idle();
        // zero trip count: every faulty scan trips at once
        load_settings(-25600, 25600, 2560, 5120, 0, MODE_CUR);
        queue_runs(120);
        wait_idle();
        load_settings(0, 76800, 12800, 6400, 5, MODE_DC1);
        queue_runs(120);
        wait_idle();
        load_settings(0, 76800, 12800, 6400, 2, MODE_DC2);
        queue_runs(120);
        wait_idle();
        // long runs drive the counters into saturation right at the trip point
        load_settings(DcMin, DcMax, 0, 0, 255, MODE_ALL);
        queue_runs(600);
        wait_idle();
        // crossed voltage limits: nearly every voltage is both low and high
        load_settings(DcMax, DcMin, DcMax, DcMax, 1, MODE_ALL);
        queue_runs(120);
        wait_idle();
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: rand_mode = MODE_OPEN_LO;
                1: rand_mode = MODE_OPEN_MID;
                2: rand_mode = MODE_OPEN_HI;
                default: rand_mode = ModeW'($urandom_range(7));
            endcase
            uv = int'($urandom_range(400000)) - 200000;
            load_settings(uv, uv + int'($urandom_range(400000)), $urandom_range(300000),
                          $urandom_range(300000), $urandom_range(6), rand_mode);
            queue_runs((k < 3) ? 80 : 120);
            wait_idle();
        end

        repeat (8) @(negedge i_clk);
        $display("Checked %0d results across %0d register settings and all sensing modes.",
                 results_checked, settings_run);
        $display("%0d results carried a trip, %0d reported a missing sensor frame.",
                 trips_seen, lost_seen);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/ifdl_pkg.sv
hw/rtl/inverter_fault_debounce_latch_top.sv
bench/tb.sv
